FILE: sv/twsw_pkg.sv
// Shared types, constants and lookup functions for the sensor word to segment write block.
package twsw_pkg;

    localparam logic [3:0] BLANK_COUNT = 4'd8;
    localparam logic [3:0] SCAN_REG    = 4'hb;
    localparam logic [7:0] POINT_BIT   = 8'h80;
    localparam int         INT_DIG_MAX = 3;

    // Per-reading control data handed from the decoder to the write sequencer
    typedef struct packed {
        logic       neg;
        logic [2:0] ndig;
    } t_dinfo;

    function automatic logic [7:0] seg_of(input logic [3:0] dig);
        logic [7:0] seg;
        unique case (dig)
            4'd0:    seg = 8'h7e;
            4'd1:    seg = 8'h30;
            4'd2:    seg = 8'h6d;
            4'd3:    seg = 8'h79;
            4'd4:    seg = 8'h33;
            4'd5:    seg = 8'h5b;
            4'd6:    seg = 8'h5f;
            4'd7:    seg = 8'h70;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h7b;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    // Sixteenths times 625 as four BCD digits, leading digit in the top nibble
    function automatic logic [15:0] frac_bcd(input logic [3:0] fr);
        logic [15:0] bcd;
        unique case (fr)
            4'd0:    bcd = 16'h0000;
            4'd1:    bcd = 16'h0625;
            4'd2:    bcd = 16'h1250;
            4'd3:    bcd = 16'h1875;
            4'd4:    bcd = 16'h2500;
            4'd5:    bcd = 16'h3125;
            4'd6:    bcd = 16'h3750;
            4'd7:    bcd = 16'h4375;
            4'd8:    bcd = 16'h5000;
            4'd9:    bcd = 16'h5625;
            4'd10:   bcd = 16'h6250;
            4'd11:   bcd = 16'h6875;
            4'd12:   bcd = 16'h7500;
            4'd13:   bcd = 16'h8125;
            4'd14:   bcd = 16'h8750;
            default: bcd = 16'h9375;
        endcase
        return bcd;
    endfunction

endpackage

FILE: sv/twsw_decode.sv
// Turns one raw sensor word into the segment patterns and digit count of its display.
module twsw_decode #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic [15:0]           i_raw,
    output logic [7:0]            o_seg [twsw_pkg::INT_DIG_MAX + FRACTION_DIGITS],
    output twsw_pkg::t_dinfo      o_info
);
    import twsw_pkg::*;

    localparam int NDIG      = INT_DIG_MAX + FRACTION_DIGITS;

    logic [11:0] v;
    logic [12:0] mag;
    logic [8:0]  ipm;
    logic [3:0]  frm;
    logic [1:0]  hund;
    logic [8:0]  rem9;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [1:0]  nint;
    logic [15:0] bcd;

    assign v   = {i_raw[14:7], i_raw[6:3]};
    // negative reading: show 256 - value as magnitude
    assign mag = i_raw[15] ? (13'd4096 - {1'b0, v}) : {1'b0, v};
    assign ipm = mag[12:4];
    assign frm = mag[3:0];
    assign bcd = frac_bcd(frm);

    always_comb begin
        priority if (ipm >= 9'd200) begin
            hund = 2'd2;
            rem9 = ipm - 9'd200;
        end else if (ipm >= 9'd100) begin
            hund = 2'd1;
            rem9 = ipm - 9'd100;
        end else begin
            hund = 2'd0;
            rem9 = ipm;
        end
    end

    assign rem  = rem9[6:0];
    // divide by ten through reciprocal multiply, exact for rem below 100
    assign prod = 15'(rem) * 15'd205;
    assign tens = prod[14:11];
    assign ones = 4'(rem - 7'(tens) * 7'd10);
    assign nint = (ipm >= 9'd100) ? 2'd3 : (ipm >= 9'd10) ? 2'd2 : 2'd1;

    always_comb begin
        for (int j = 0; j < NDIG; j++) begin
            logic [2:0] jj;
            logic [1:0] pos;
            logic [1:0] fi;
            logic [3:0] dig;
            jj  = 3'(j);
            pos = 2'(jj + 3'd3 - {1'b0, nint});
            fi  = 2'(jj - {1'b0, nint});
            if (jj < {1'b0, nint}) begin
                unique case (pos)
                    2'd0:    dig = {2'b00, hund};
                    2'd1:    dig = tens;
                    2'd2:    dig = ones;
                    default: dig = 4'd0;
                endcase
            end else begin
                unique case (fi)
                    2'd0:    dig = bcd[15:12];
                    2'd1:    dig = bcd[11:8];
                    2'd2:    dig = bcd[7:4];
                    default: dig = bcd[3:0];
                endcase
            end
            o_seg[j] = seg_of(dig);
            if (jj == {1'b0, nint} - 3'd1) begin
                o_seg[j] = seg_of(dig) | POINT_BIT;
            end
        end
    end

    assign o_info.neg  = i_raw[15];
    assign o_info.ndig = {1'b0, nint} + 3'(FRACTION_DIGITS);

endmodule

FILE: sv/temp_word_to_segment_writes.sv
// Top level: sensor word in, run of display driver register writes out.
//
//  channel   dir  tdata                              tuser          tlast
//  s (in)    in   raw_word[15:0]                     -              -
//  m (out)   out  reg_addr[3:0], reg_data[11:4]      negative_flag  last_write
//
// One reading gives 9 + nint + FRACTION_DIGITS writes (nint 1..3), one per cycle
// while the output does not stall; 14..16 writes with four fraction digits, set
// by the write sequencer's counter. The first write passes the input word register,
// the sequencer and the output word register; the next word is taken and decoded
// while the current run is still being written.
// Reset (synchronous, active low) clears the valid flags and the sequencer.
// A stall on the output holds the current write and freezes the sequencer.
module temp_word_to_segment_writes #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] raw_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [3:0] reg_addr, [11:4] reg_data, [15:12] zero
    output logic        o_m_tuser,   // [0] negative_flag
    output logic        o_m_tlast
);
    import twsw_pkg::*;

    localparam int NDIG = INT_DIG_MAX + FRACTION_DIGITS;
    localparam int IW   = $clog2(NDIG);

    logic        r_in_vld;
    logic [15:0] r_in_raw;

    logic [7:0]  dec_seg [NDIG];
    t_dinfo      dec_info;

    logic        r_busy;
    logic [3:0]  r_k;
    logic [7:0]  r_seg [NDIG];
    t_dinfo      r_info;

    logic        r_out_vld;
    logic [3:0]  r_out_addr;
    logic [7:0]  r_out_data;
    logic        r_out_neg;
    logic        r_out_last;

    logic        emit_fire;
    logic        emit_last;
    logic        load;
    logic [3:0]  j4;
    logic [3:0]  n_addr;
    logic [7:0]  n_data;

    twsw_decode #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_decode (
        .i_raw  (r_in_raw),
        .o_seg  (dec_seg),
        .o_info (dec_info)
    );

    assign emit_fire  = r_busy && (!r_out_vld || i_m_tready);
    assign emit_last  = (r_k == BLANK_COUNT + {1'b0, r_info.ndig});
    assign load       = r_in_vld && (!r_busy || (emit_fire && emit_last));
    assign o_s_tready = !r_in_vld || load;

    assign j4 = r_k - (BLANK_COUNT + 4'd1);

    always_comb begin
        priority if (r_k < BLANK_COUNT) begin
            n_addr = r_k + 4'd1;
            n_data = 8'h00;
        end else if (r_k == BLANK_COUNT) begin
            n_addr = SCAN_REG;
            n_data = {5'b0, r_info.ndig - 3'd1};
        end else begin
            n_addr = j4 + 4'd1;
            n_data = r_seg[j4[IW-1:0]];
        end
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_raw <= i_s_tdata;
        end
    end

    // write sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 4'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_k    <= 4'd0;
        end else if (emit_fire) begin
            r_busy <= !emit_last;
            r_k    <= r_k + 4'd1;
        end
        if (load) begin
            r_seg  <= dec_seg;
            r_info <= dec_info;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
        if (emit_fire) begin
            r_out_addr <= n_addr;
            r_out_data <= n_data;
            r_out_neg  <= r_info.neg;
            r_out_last <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0, r_out_data, r_out_addr};
    assign o_m_tuser  = r_out_neg;
    assign o_m_tlast  = r_out_last;

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k <= BLANK_COUNT + {1'b0, r_info.ndig}))
        else $error("sequencer ran past the last write");

    a_scan_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3:0] == SCAN_REG) |-> !o_m_tlast)
        else $error("run ended on the scan limit write");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast)
            |=> (!o_m_tvalid || (o_m_tdata[3:0] == 4'd1 && o_m_tdata[11:4] == 8'h00)))
        else $error("new run did not open with a blanking write to digit 1");

    a_last_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> !o_m_tdata[11])
        else $error("decimal point set on a fraction digit");

endmodule
